// ----- hdl/ssc_pkg.sv -----
// ----------------------------------------------------------------------------
// ssc_pkg
// Shared types and constants of the sample stream consolidator.
// ----------------------------------------------------------------------------
package ssc_pkg;

  localparam int SAMPLE_WIDTH = 32;
  localparam int FACTOR_WIDTH = 16;
  localparam int ACC_WIDTH    = (SAMPLE_WIDTH + FACTOR_WIDTH > 64) ? 64
                                : (SAMPLE_WIDTH + FACTOR_WIDTH);
  localparam int STEP_WIDTH   = $clog2(ACC_WIDTH);
  localparam int JOB_DEPTH    = 2;
  localparam int APB_DATA_WIDTH = 32;
  localparam int APB_ADDR_WIDTH = 3;

  // Register indexes, taken from address bit 2.
  localparam logic REG_MODE   = 1'b0;
  localparam logic REG_FACTOR = 1'b1;

  typedef enum logic [1:0] {
    MODE_MAX  = 2'd0,
    MODE_MIN  = 2'd1,
    MODE_AVG  = 2'd2,
    MODE_LAST = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_DONE
  } back_state_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic                           sample_valid;
    logic                           first_of_series;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] result;
    logic                           result_valid;
  } out_t;

  // One finished group (or one pass-through sample) handed to the back end.
  typedef struct packed {
    logic signed [ACC_WIDTH-1:0] acc;
    logic                        acc_valid;
    logic [FACTOR_WIDTH-1:0]     count;
    logic                        is_avg;
  } job_t;

endpackage

// ----- hdl/ssc_front.sv -----
// ----------------------------------------------------------------------------
// ssc_front
// Accepts samples, folds them into the group accumulator and emits one job
// per finished group or per pass-through sample.
// ----------------------------------------------------------------------------
module ssc_front import ssc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  mode_t                   mode,
  input  logic [FACTOR_WIDTH-1:0] factor,
  input  logic                    push,
  output logic                    full,
  input  in_t                     in_data,
  output logic                    job_push,
  output job_t                    job,
  input  logic                    job_full
);

  localparam logic signed [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
  localparam logic signed [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};

  logic signed [ACC_WIDTH-1:0] acc_r, acc_nxt;
  logic                        accv_r, accv_nxt;
  logic [FACTOR_WIDTH-1:0]     cnt_r, cnt_nxt;
  logic [FACTOR_WIDTH-1:0]     pos_r, pos_nxt;

  logic                        accept;
  logic                        pass;
  logic                        group_end;
  logic [FACTOR_WIDTH-1:0]     pos_eff;
  logic signed [ACC_WIDTH-1:0] smp_ext;
  logic signed [ACC_WIDTH:0]   sum;
  logic signed [ACC_WIDTH-1:0] sum_sat;
  logic signed [ACC_WIDTH-1:0] fold_acc;
  logic                        fold_accv;
  logic [FACTOR_WIDTH-1:0]     fold_cnt;

  assign full    = job_full;
  assign accept  = push & ~job_full;
  assign pass    = (factor[FACTOR_WIDTH-1:1] == '0);
  assign pos_eff = in_data.first_of_series ? '0 : pos_r;
  assign group_end = (pos_eff >= (factor - 1'b1));
  assign smp_ext = ACC_WIDTH'(in_data.sample);
  assign sum     = (ACC_WIDTH+1)'(acc_r) + (ACC_WIDTH+1)'(smp_ext);

  always_comb begin
    if (sum[ACC_WIDTH] != sum[ACC_WIDTH-1]) begin
      sum_sat = sum[ACC_WIDTH] ? ACC_MIN : ACC_MAX;
    end else begin
      sum_sat = sum[ACC_WIDTH-1:0];
    end
  end

  // Fold the incoming sample with the current mode.
  always_comb begin
    fold_acc  = acc_r;
    fold_accv = accv_r;
    fold_cnt  = cnt_r;
    if (mode == MODE_LAST) begin
      fold_acc  = in_data.sample_valid ? smp_ext : '0;
      fold_accv = in_data.sample_valid;
    end else if (in_data.sample_valid) begin
      fold_accv = 1'b1;
      if (!accv_r) begin
        fold_acc = smp_ext;
      end else begin
        case (mode)
          MODE_MAX: fold_acc = (smp_ext > acc_r) ? smp_ext : acc_r;
          MODE_MIN: fold_acc = (smp_ext < acc_r) ? smp_ext : acc_r;
          default:  fold_acc = sum_sat;
        endcase
      end
      if (mode == MODE_AVG && cnt_r != '1) begin
        fold_cnt = cnt_r + 1'b1;
      end
    end
  end

  always_comb begin
    acc_nxt  = acc_r;
    accv_nxt = accv_r;
    cnt_nxt  = cnt_r;
    pos_nxt  = pos_r;
    job_push = 1'b0;
    job.acc       = smp_ext;
    job.acc_valid = in_data.sample_valid;
    job.count     = '0;
    job.is_avg    = 1'b0;
    if (accept) begin
      if (pass) begin
        job_push = 1'b1;
      end else if (group_end) begin
        job_push      = 1'b1;
        job.acc       = fold_acc;
        job.acc_valid = fold_accv;
        job.count     = fold_cnt;
        job.is_avg    = (mode == MODE_AVG);
        acc_nxt  = '0;
        accv_nxt = 1'b0;
        cnt_nxt  = '0;
        pos_nxt  = '0;
      end else begin
        acc_nxt  = fold_acc;
        accv_nxt = fold_accv;
        cnt_nxt  = fold_cnt;
        pos_nxt  = pos_eff + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      accv_r <= 1'b0;
      cnt_r  <= '0;
      pos_r  <= '0;
    end else begin
      acc_r  <= acc_nxt;
      accv_r <= accv_nxt;
      cnt_r  <= cnt_nxt;
      pos_r  <= pos_nxt;
    end
  end

endmodule

// ----- hdl/ssc_job_fifo.sv -----
// ----------------------------------------------------------------------------
// ssc_job_fifo
// Short queue of jobs between the front and the back end.
// ----------------------------------------------------------------------------
module ssc_job_fifo import ssc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t din,
  output logic full,
  input  logic pop,
  output job_t dout,
  output logic empty
);

  localparam int PTR_WIDTH = (JOB_DEPTH > 1) ? $clog2(JOB_DEPTH) : 1;
  localparam int CNT_WIDTH = $clog2(JOB_DEPTH + 1);
  localparam logic [PTR_WIDTH-1:0] LAST_PTR = PTR_WIDTH'(JOB_DEPTH - 1);

  job_t                 mem_r [JOB_DEPTH];
  logic [PTR_WIDTH-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_WIDTH-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_WIDTH-1:0] count_r, count_nxt;
  logic                 do_push;
  logic                 do_pop;

  assign full    = (count_r == CNT_WIDTH'(JOB_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign dout    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

// ----- hdl/ssc_back.sv -----
// ----------------------------------------------------------------------------
// ssc_back
// Turns jobs into results: rounded average by a bit-serial divider,
// saturation to the sample range, and the result register.
// ----------------------------------------------------------------------------
module ssc_back import ssc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic job_avail,
  input  job_t job,
  output logic job_pop,
  output out_t out_data,
  output logic empty,
  input  logic pop
);

  localparam int VAL_WIDTH = ACC_WIDTH + 2;
  localparam logic signed [VAL_WIDTH-1:0] VAL_MAX =
    {{(VAL_WIDTH-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [VAL_WIDTH-1:0] VAL_MIN = ~VAL_MAX;

  back_state_t                 state_r, state_nxt;
  logic signed [ACC_WIDTH-1:0] acc_r, acc_nxt;
  logic                        neg_r, neg_nxt;
  logic                        accv_r, accv_nxt;
  logic                        div_r, div_nxt;
  logic [FACTOR_WIDTH-1:0]     count_r, count_nxt;
  logic [ACC_WIDTH-1:0]        quo_r, quo_nxt;
  logic [FACTOR_WIDTH-1:0]     rem_r, rem_nxt;
  logic [STEP_WIDTH-1:0]       step_r, step_nxt;
  out_t                        out_r, out_nxt;
  logic                        out_vld_r, out_vld_nxt;

  logic [ACC_WIDTH-1:0]        mag;
  logic [FACTOR_WIDTH:0]       trial;
  logic                        trial_ge;
  logic                        round_up;
  logic [ACC_WIDTH:0]          q_rnd;
  logic signed [VAL_WIDTH-1:0] q_val;
  logic signed [VAL_WIDTH-1:0] val;
  logic signed [SAMPLE_WIDTH-1:0] val_sat;
  logic                        slot_free;

  assign out_data  = out_r;
  assign empty     = ~out_vld_r;
  assign slot_free = ~out_vld_r | pop;

  assign mag      = job.acc[ACC_WIDTH-1] ? ACC_WIDTH'(-job.acc) : ACC_WIDTH'(job.acc);
  assign trial    = {rem_r, quo_r[ACC_WIDTH-1]};
  assign trial_ge = (trial >= {1'b0, count_r});
  assign round_up = ({rem_r, 1'b0} >= {1'b0, count_r});
  assign q_rnd    = {1'b0, quo_r} + (ACC_WIDTH+1)'(round_up);
  assign q_val    = neg_r ? -$signed({1'b0, q_rnd}) : $signed({1'b0, q_rnd});
  assign val      = div_r ? q_val : VAL_WIDTH'(acc_r);

  always_comb begin
    if (val > VAL_MAX) begin
      val_sat = VAL_MAX[SAMPLE_WIDTH-1:0];
    end else if (val < VAL_MIN) begin
      val_sat = VAL_MIN[SAMPLE_WIDTH-1:0];
    end else begin
      val_sat = val[SAMPLE_WIDTH-1:0];
    end
  end

  always_comb begin
    state_nxt   = state_r;
    acc_nxt     = acc_r;
    neg_nxt     = neg_r;
    accv_nxt    = accv_r;
    div_nxt     = div_r;
    count_nxt   = count_r;
    quo_nxt     = quo_r;
    rem_nxt     = rem_r;
    step_nxt    = step_r;
    out_nxt     = out_r;
    out_vld_nxt = out_vld_r & ~pop;
    job_pop     = 1'b0;
    case (state_r)
      BK_IDLE: begin
        if (job_avail) begin
          job_pop   = 1'b1;
          acc_nxt   = job.acc;
          neg_nxt   = job.acc[ACC_WIDTH-1];
          accv_nxt  = job.acc_valid;
          count_nxt = job.count;
          quo_nxt   = mag;
          rem_nxt   = '0;
          step_nxt  = STEP_WIDTH'(ACC_WIDTH - 1);
          div_nxt   = job.is_avg & job.acc_valid & (job.count != '0);
          state_nxt = div_nxt ? BK_DIV : BK_DONE;
        end
      end
      BK_DIV: begin
        rem_nxt  = trial_ge ? FACTOR_WIDTH'(trial - {1'b0, count_r})
                            : trial[FACTOR_WIDTH-1:0];
        quo_nxt  = {quo_r[ACC_WIDTH-2:0], trial_ge};
        step_nxt = step_r - 1'b1;
        if (step_r == '0) begin
          state_nxt = BK_DONE;
        end
      end
      BK_DONE: begin
        if (slot_free) begin
          out_nxt.result       = accv_r ? val_sat : '0;
          out_nxt.result_valid = accv_r;
          out_vld_nxt          = 1'b1;
          state_nxt            = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= BK_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r   <= acc_nxt;
    neg_r   <= neg_nxt;
    accv_r  <= accv_nxt;
    div_r   <= div_nxt;
    count_r <= count_nxt;
    quo_r   <= quo_nxt;
    rem_r   <= rem_nxt;
    step_r  <= step_nxt;
    out_r   <= out_nxt;
  end

endmodule

// ----- hdl/sample_stream_consolidator_top.sv -----
// ----------------------------------------------------------------------------
// sample_stream_consolidator_top
// Folds a stream of Q16.16 samples into one result per group of
// decimation_factor samples, by maximum, minimum, average or last value.
// ----------------------------------------------------------------------------
// The front end takes one sample transfer per cycle while full is low and
// folds it into the group accumulator in that same cycle. A sample that
// closes a group, and every sample when the decimation factor is 0 or 1
// (pass-through), becomes a job in a two-entry queue, and full stays high
// only while that queue is full. The back end takes one job at a time:
// maximum, minimum, last and pass-through results go from the idle state
// to the done state, while an average runs a bit-serial divider of one
// quotient bit per cycle over the 48-bit accumulator magnitude. The
// divider therefore sets the sustained rate when short average groups
// follow each other; long groups run at one sample per cycle. Results
// leave in order through a one-entry output register, and the back end
// may finish a new result in the cycle the waiting one is popped. The
// averages are rounded to nearest with ties away from zero, and every
// result saturates to the 32-bit sample range. Mode and decimation
// factor are written over the APB port at byte addresses 0 and 4 and
// should only change while no result is outstanding.
// ----------------------------------------------------------------------------
module sample_stream_consolidator_top import ssc_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  // Input channel
  input  logic                      push,
  output logic                      full,
  input  in_t                       in_data,
  // Result channel
  output logic                      empty,
  input  logic                      pop,
  output out_t                      out_data,
  // Configuration port
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [APB_ADDR_WIDTH-1:0] paddr,
  input  logic [APB_DATA_WIDTH-1:0] pwdata,
  output logic [APB_DATA_WIDTH-1:0] prdata,
  output logic                      pready
);

  mode_t                   mode_r;
  logic [FACTOR_WIDTH-1:0] factor_r;
  logic                    cfg_write;

  logic                    job_push;
  job_t                    job_in;
  logic                    job_full;
  logic                    job_pop;
  job_t                    job_out;
  logic                    job_empty;

  // The port never inserts wait states; a write lands in the access phase.
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_MAX;
      factor_r <= FACTOR_WIDTH'(1);
    end else if (cfg_write) begin
      case (paddr[2])
        REG_MODE:   mode_r   <= mode_t'(pwdata[1:0]);
        REG_FACTOR: factor_r <= pwdata[FACTOR_WIDTH-1:0];
        default:    mode_r   <= mode_r;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_MODE:   prdata = APB_DATA_WIDTH'(mode_r);
      REG_FACTOR: prdata = APB_DATA_WIDTH'(factor_r);
      default:    prdata = '0;
    endcase
  end

  // Accumulation and group counting.
  ssc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .mode     (mode_r),
    .factor   (factor_r),
    .push     (push),
    .full     (full),
    .in_data  (in_data),
    .job_push (job_push),
    .job      (job_in),
    .job_full (job_full)
  );

  // Decouples the front end from the back end and its serial divider.
  ssc_job_fifo u_job_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (job_push),
    .din   (job_in),
    .full  (job_full),
    .pop   (job_pop),
    .dout  (job_out),
    .empty (job_empty)
  );

  // Averaging divider, saturation and result register.
  ssc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_avail (~job_empty),
    .job       (job_out),
    .job_pop   (job_pop),
    .out_data  (out_data),
    .empty     (empty),
    .pop       (pop)
  );

endmodule

// ----- sim/ssc_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ssc_checker
// Watches the sample, result and register traffic of the sample stream
// consolidator, predicts each group result and compares it field by field.
// ----------------------------------------------------------------------------
module ssc_checker import ssc_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      push,
  input  logic                      full,
  input  in_t                       in_data,
  input  logic                      empty,
  input  logic                      pop,
  input  out_t                      out_data,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [APB_ADDR_WIDTH-1:0] paddr,
  input  logic [APB_DATA_WIDTH-1:0] pwdata,
  input  logic                      pready,
  output int                        fail_count,
  output int                        results_due,
  output int                        results_checked
);

  localparam longint ACC_HI = (64'sd1 <<< (ACC_WIDTH - 1)) - 1;
  localparam longint ACC_LO = -ACC_HI - 1;
  localparam longint SMP_HI = (64'sd1 <<< (SAMPLE_WIDTH - 1)) - 1;
  localparam longint SMP_LO = -SMP_HI - 1;

  // Shadow of the registers and of the group state.
  mode_t                   cur_mode;
  logic [FACTOR_WIDTH-1:0] cur_factor;
  longint                  group_acc;
  bit                      group_acc_ok;
  logic [FACTOR_WIDTH-1:0] group_valid_cnt;
  logic [FACTOR_WIDTH-1:0] group_pos;

  out_t pending_results[$];

  initial begin
    fail_count      = 0;
    results_due     = 0;
    results_checked = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    fail_count++;
  endtask

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // Rounded to nearest, ties away from zero.
  function automatic longint rounded_mean(input longint sum, input logic [FACTOR_WIDTH-1:0] n);
    longint cnt;
    longint mag;
    longint q;
    longint rem;
    cnt = n;
    mag = (sum < 0) ? -sum : sum;
    q   = mag / cnt;
    rem = mag % cnt;
    if (rem >= cnt - rem) q++;
    return (sum < 0) ? -q : q;
  endfunction

  // Folds one sample into the group; returns 1 when a result comes out.
  function automatic bit fold_sample(input in_t s, output out_t r);
    longint v;
    longint total;
    r = '0;
    v = longint'($signed(s.sample));
    if (cur_factor <= 1) begin
      r.result       = s.sample_valid ? s.sample : '0;
      r.result_valid = s.sample_valid;
      return 1'b1;
    end
    if (s.first_of_series) group_pos = '0;
    if (cur_mode == MODE_LAST) begin
      group_acc    = s.sample_valid ? v : 0;
      group_acc_ok = s.sample_valid;
    end else if (s.sample_valid) begin
      if (!group_acc_ok) begin
        group_acc = v;
      end else begin
        case (cur_mode)
          MODE_MAX: if (v > group_acc) group_acc = v;
          MODE_MIN: if (v < group_acc) group_acc = v;
          default:  group_acc = clamp(group_acc + v, ACC_LO, ACC_HI);
        endcase
      end
      group_acc_ok = 1'b1;
      if (cur_mode == MODE_AVG && group_valid_cnt != '1) group_valid_cnt++;
    end
    if (group_pos >= cur_factor - 1'b1) begin
      total = group_acc;
      if (cur_mode == MODE_AVG && group_valid_cnt != 0)
        total = rounded_mean(group_acc, group_valid_cnt);
      total          = clamp(total, SMP_LO, SMP_HI);
      r.result       = group_acc_ok ? total[SAMPLE_WIDTH-1:0] : '0;
      r.result_valid = group_acc_ok;
      group_acc       = 0;
      group_acc_ok    = 1'b0;
      group_valid_cnt = '0;
      group_pos       = '0;
      return 1'b1;
    end
    group_pos++;
    return 1'b0;
  endfunction

  always @(posedge clk) begin
    out_t want;
    out_t made;
    if (!rst_n) begin
      cur_mode        = MODE_MAX;
      cur_factor      = 1;
      group_acc       = 0;
      group_acc_ok    = 1'b0;
      group_valid_cnt = '0;
      group_pos       = '0;
      pending_results.delete();
    end else begin
      // A result cannot leave in the cycle its sample arrives, so the
      // comparison goes first.
      if (pop && !empty) begin
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("result transfer %h/%b with nothing awaited",
                                    out_data.result, out_data.result_valid));
        end else begin
          want = pending_results.pop_front();
          if (out_data.result_valid !== want.result_valid)
            report_mismatch($sformatf("result_valid %b, predicted %b",
                                      out_data.result_valid, want.result_valid));
          if (out_data.result !== want.result)
            report_mismatch($sformatf("result %h, predicted %h",
                                      out_data.result, want.result));
        end
        results_checked++;
      end
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_FACTOR) cur_factor = pwdata[FACTOR_WIDTH-1:0];
        else                        cur_mode   = mode_t'(pwdata[1:0]);
      end
      if (push && !full) begin
        if (fold_sample(in_data, made)) pending_results.push_back(made);
      end
    end
    results_due = pending_results.size();
  end

endmodule

// ----- sim/sample_stream_consolidator_top_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sample_stream_consolidator_top_tb
// Drives sample transfers and register writes into the consolidator, pops
// its results under random stalls and lets ssc_checker judge every result.
// ----------------------------------------------------------------------------
module sample_stream_consolidator_top_tb;
  import ssc_pkg::*;

  localparam int CLK_PERIOD    = 10;
  localparam int LIMIT_CYCLES  = 1_000_000;
  localparam int RANDOM_ITEMS  = 950;
  // Idle stretch between the last result of one phase and the next writes.
  localparam int SETTLE_CYCLES = 64;
  localparam int HOLD_CYCLES   = 300;

  logic                      clk;
  logic                      rst_n   = 1'b0;
  logic                      push    = 1'b0;
  logic                      full;
  in_t                       in_data = '0;
  logic                      empty;
  logic                      pop     = 1'b0;
  out_t                      out_data;
  logic                      psel    = 1'b0;
  logic                      penable = 1'b0;
  logic                      pwrite  = 1'b0;
  logic [APB_ADDR_WIDTH-1:0] paddr   = '0;
  logic [APB_DATA_WIDTH-1:0] pwdata  = '0;
  logic [APB_DATA_WIDTH-1:0] prdata;
  logic                      pready;

  int fail_count;
  int results_due;
  int results_checked;

  // Knobs shared between the sample process and the result process.
  bit tx_idle_en = 1'b1;
  bit rx_idle_en = 1'b1;
  int rx_hold    = 0;

  int samples_sent = 0;
  int phase_count  = 0;

  sample_stream_consolidator_top u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_data  (in_data),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  ssc_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_data         (in_data),
    .empty           (empty),
    .pop             (pop),
    .out_data        (out_data),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .pready          (pready),
    .fail_count      (fail_count),
    .results_due     (results_due),
    .results_checked (results_checked)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Hard stop in case the block hangs on either handshake.
  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("sample_stream_consolidator_top_tb: FAIL");
    $finish;
  end

  // Wait drawn before each transfer on either side. A phase with idling
  // switched off gives back-to-back transfers.
  function automatic int draw_gap(input bit en);
    return en ? int'($urandom_range(0, 14)) : 0;
  endfunction

  function automatic in_t mk_sample(input logic [SAMPLE_WIDTH-1:0] v, input bit ok,
                                    input bit first);
    in_t s;
    s.sample          = v;
    s.sample_valid    = ok;
    s.first_of_series = first;
    return s;
  endfunction

  // Mixes the range extremes, small values (which make rounding ties
  // likely in average groups) and fully random words.
  function automatic logic [SAMPLE_WIDTH-1:0] draw_value();
    case ($urandom_range(0, 7))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2, 3:    return $urandom_range(0, 2000) - 32'd1000;
      default: return $urandom();
    endcase
  endfunction

  // One sample transfer. Every call is entered and left at a falling edge,
  // so push and in_data only ever change there. push stays high on return,
  // and the next call either lowers it or reuses it for a back-to-back
  // transfer, so it is never lowered and raised in the same step.
  task automatic send_sample(input in_t s);
    int gap;
    gap = draw_gap(tx_idle_en);
    if (gap > 0) begin
      push = 1'b0;
      repeat (gap) @(negedge clk);
    end
    push    = 1'b1;
    in_data = s;
    do @(posedge clk); while (full);
    @(negedge clk);
    samples_sent++;
  endtask

  // Stops the sample stream and waits until every predicted result has
  // been popped, after which the block holds no work. A short idle pause
  // follows before the register writes.
  task automatic wait_drained();
    push = 1'b0;
    while (results_due != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // APB write: setup cycle, then the access cycle, which completes at the
  // rising edge where pready is high.
  task automatic cfg_write(input logic idx, input logic [APB_DATA_WIDTH-1:0] value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic start_phase(input mode_t m, input logic [FACTOR_WIDTH-1:0] f);
    wait_drained();
    cfg_write(REG_MODE, APB_DATA_WIDTH'(m));
    cfg_write(REG_FACTOR, APB_DATA_WIDTH'(f));
    phase_count++;
  endtask

  // Result side: pop is raised after a drawn wait and held until a transfer
  // completes. A hold request from the stimulus adds a long stretch, counted
  // here, during which the block's queues fill up and full rises.
  initial begin
    int gap;
    do @(negedge clk); while (!rst_n);
    forever begin
      gap = draw_gap(rx_idle_en);
      if (rx_hold > 0) begin
        gap     = gap + rx_hold;
        rx_hold = 0;
      end
      if (gap > 0) begin
        pop = 1'b0;
        repeat (gap) @(negedge clk);
      end
      pop = 1'b1;
      do @(posedge clk); while (empty);
      @(negedge clk);
    end
  end

  initial begin
    mode_t                   m;
    logic [FACTOR_WIDTH-1:0] f;
    int                      n_items;
    int                      valid_weight;
    int                      random_sent;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // ---- Directed part ----
    // Reset values give pass-through: extremes, a sample marked as missing
    // (its value must not leak out) and a series-start flag that is ignored.
    send_sample(mk_sample(32'h7fff_ffff, 1'b1, 1'b0));
    send_sample(mk_sample(32'h8000_0000, 1'b1, 1'b1));
    send_sample(mk_sample(32'h1234_5678, 1'b0, 1'b0));

    // A factor of zero is pass-through as well.
    start_phase(MODE_LAST, 16'd0);
    send_sample(mk_sample(32'hffff_ffff, 1'b1, 1'b0));

    // Maximum over three, skipping a missing sample. Then a series start in
    // the middle of a group restarts counting but keeps the running maximum.
    start_phase(MODE_MAX, 16'd3);
    send_sample(mk_sample(32'h1234_0000, 1'b0, 1'b0));
    send_sample(mk_sample(32'hfffb_0000, 1'b1, 1'b0));
    send_sample(mk_sample(32'h0007_0000, 1'b1, 1'b0));
    send_sample(mk_sample(32'h000a_0000, 1'b1, 1'b0));
    send_sample(mk_sample(32'h0014_0000, 1'b1, 1'b1));
    send_sample(mk_sample(32'h0000_0001, 1'b1, 1'b0));
    send_sample(mk_sample(32'h0000_0002, 1'b1, 1'b0));

    start_phase(MODE_MIN, 16'd2);
    send_sample(mk_sample(32'h7fff_ffff, 1'b1, 1'b0));
    send_sample(mk_sample(32'h8000_0000, 1'b1, 1'b0));

    // Average with ties on both signs: 1.5 ulp goes up, -1.5 ulp goes down.
    start_phase(MODE_AVG, 16'd2);
    send_sample(mk_sample(32'h0000_0001, 1'b1, 1'b0));
    send_sample(mk_sample(32'h0000_0002, 1'b1, 1'b0));
    send_sample(mk_sample(32'hffff_ffff, 1'b1, 1'b0));
    send_sample(mk_sample(32'hffff_fffe, 1'b1, 1'b0));

    // Two maximum values summed, then the group is closed in maximum mode:
    // the raw sum is the result and has to saturate.
    start_phase(MODE_AVG, 16'd3);
    send_sample(mk_sample(32'h7fff_ffff, 1'b1, 1'b0));
    send_sample(mk_sample(32'h7fff_ffff, 1'b1, 1'b0));
    start_phase(MODE_MAX, 16'd3);
    send_sample(mk_sample(32'h0000_0000, 1'b1, 1'b0));

    // A value taken in maximum mode, then the group is closed in average
    // mode with no counted samples: the accumulator passes through as is.
    send_sample(mk_sample(32'h0003_0000, 1'b1, 1'b0));
    start_phase(MODE_AVG, 16'd3);
    send_sample(mk_sample(32'h0000_0000, 1'b0, 1'b0));
    send_sample(mk_sample(32'h0000_0000, 1'b0, 1'b0));

    // Last mode keeps a trailing missing sample, so the result is missing.
    start_phase(MODE_LAST, 16'd2);
    send_sample(mk_sample(32'h0000_0005, 1'b1, 1'b0));
    send_sample(mk_sample(32'h0000_0009, 1'b0, 1'b0));

    // Largest factor, then lowered below the group position: the next
    // sample closes the group at once.
    start_phase(MODE_MAX, 16'hffff);
    send_sample(mk_sample(32'hdead_beef, 1'b1, 1'b0));
    send_sample(mk_sample(32'h0000_0010, 1'b1, 1'b0));
    send_sample(mk_sample(32'h0000_0020, 1'b0, 1'b0));
    start_phase(MODE_MAX, 16'd2);
    send_sample(mk_sample(32'h0000_0030, 1'b1, 1'b0));

    // ---- Random part ----
    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      if (phase_count == 14) begin
        // Back pressure: pass-through samples sent back to back while the
        // result side holds off, so the job queue fills and full rises.
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        start_phase(MODE_MAX, 16'd1);
        rx_hold = HOLD_CYCLES;
        repeat (40) begin
          send_sample(mk_sample(draw_value(), $urandom_range(0, 7) != 0, 1'b0));
          random_sent++;
        end
      end
      m = mode_t'($urandom_range(0, 3));
      case ($urandom_range(0, 9))
        0:       f = FACTOR_WIDTH'($urandom_range(0, 1));
        7, 8:    f = FACTOR_WIDTH'($urandom_range(7, 40));
        default: f = FACTOR_WIDTH'($urandom_range(2, 6));
      endcase
      tx_idle_en   = $urandom_range(0, 2) != 0;
      rx_idle_en   = $urandom_range(0, 2) != 0;
      // Some phases are mostly missing samples, so empty groups turn up.
      valid_weight = ($urandom_range(0, 4) == 0) ? 2 : 8;
      n_items      = $urandom_range(20, 60);
      start_phase(m, f);
      repeat (n_items) begin
        send_sample(mk_sample(draw_value(),
                              $urandom_range(0, 9) < valid_weight,
                              $urandom_range(0, 15) == 0));
        random_sent++;
      end
    end

    wait_drained();

    $display("Covered %0d sample transfers over %0d register settings in all four modes.",
             samples_sent, phase_count);
    $display("Checked %0d result transfers, %0d mismatches.", results_checked, fail_count);
    if (fail_count == 0) begin
      $display("sample_stream_consolidator_top_tb: PASS");
    end else begin
      $display("sample_stream_consolidator_top_tb: FAIL");
    end
    $finish;
  end

endmodule
